// File: hdl/csot_pkg.sv
`timescale 1ns / 1ps

package csot_pkg;

    localparam int CW = 32;
    localparam int EW = CW + 3;
    localparam int MW = CW + 1;
    localparam int SW = 2 * MW;

    typedef enum logic [2:0] {
        OP_POINT_CIRCLE   = 3'd0,
        OP_POINT_SQUARE   = 3'd1,
        OP_CIRCLE_CIRCLE  = 3'd2,
        OP_SQUARE_SQUARE  = 3'd3,
        OP_CIRCLE_SQUARE  = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]           operation;
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        logic [CW-2:0]        first_size;
        logic signed [CW-1:0] second_x;
        logic signed [CW-1:0] second_y;
        logic [CW-2:0]        second_size;
        logic signed [CW-1:0] tolerance;
    } item_t;

    typedef struct packed {
        logic          direct;
        logic          direct_hit;
        logic [MW-1:0] dx_mag;
        logic [MW-1:0] dy_mag;
        logic [MW-1:0] thr;
    } prep_t;

endpackage

// File: hdl/csot_geom.sv
`timescale 1ns / 1ps

module csot_geom (
    input  csot_pkg::item_t item,
    output csot_pkg::prep_t prep
);
    import csot_pkg::*;

    function automatic logic [MW-1:0] mag_of(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] a;
        a = (v < 0) ? -v : v;
        return a[MW-1:0];
    endfunction

    logic signed [EW-1:0] ax_e, ay_e, as_e, bx_e, by_e, bs_e, eps_e;
    logic signed [EW-1:0] d_x, d_y, abs_x, abs_y, sum_s, gx, gy;
    logic signed [EW-1:0] lo_x, hi_x, lo_y, hi_y, qx, qy, cx, cy;
    logic signed [EW-1:0] vx, vy, t;
    logic                 in_sq, direct, direct_hit;

    assign ax_e  = EW'(item.first_x);
    assign ay_e  = EW'(item.first_y);
    assign as_e  = EW'(item.first_size);
    assign bx_e  = EW'(item.second_x);
    assign by_e  = EW'(item.second_y);
    assign bs_e  = EW'(item.second_size);
    assign eps_e = EW'(item.tolerance);

    assign d_x   = bx_e - ax_e;
    assign d_y   = by_e - ay_e;
    assign abs_x = (d_x < 0) ? -d_x : d_x;
    assign abs_y = (d_y < 0) ? -d_y : d_y;
    assign sum_s = as_e + bs_e;
    assign gx    = abs_x - sum_s;
    assign gy    = abs_y - sum_s;

    assign lo_x = bx_e - bs_e;
    assign hi_x = bx_e + bs_e;
    assign lo_y = by_e - bs_e;
    assign hi_y = by_e + bs_e;
    assign qx   = (ax_e < lo_x) ? lo_x : ((ax_e > hi_x) ? hi_x : ax_e);
    assign qy   = (ay_e < lo_y) ? lo_y : ((ay_e > hi_y) ? hi_y : ay_e);
    assign cx   = ax_e - qx;
    assign cy   = ay_e - qy;

    assign in_sq = (bx_e > ax_e - as_e + eps_e) && (bx_e < ax_e + as_e - eps_e) &&
                   (by_e > ay_e - as_e + eps_e) && (by_e < ay_e + as_e - eps_e);

    always_comb
    begin
        vx         = '0;
        vy         = '0;
        t          = '0;
        direct     = 1'b0;
        direct_hit = 1'b0;
        unique case (item.operation)
            OP_POINT_CIRCLE:
            begin
                vx = d_x;
                vy = d_y;
                t  = as_e - eps_e;
            end
            OP_POINT_SQUARE:
            begin
                direct     = 1'b1;
                direct_hit = in_sq;
            end
            OP_CIRCLE_CIRCLE:
            begin
                vx = d_x;
                vy = d_y;
                t  = sum_s + eps_e;
            end
            OP_SQUARE_SQUARE:
            begin
                if (gx < 0 && gy < 0)
                begin
                    direct     = 1'b1;
                    direct_hit = 1'b1;
                end
                else
                begin
                    vx = (gx > 0) ? gx : '0;
                    vy = (gy > 0) ? gy : '0;
                    t  = eps_e;
                end
            end
            OP_CIRCLE_SQUARE:
            begin
                vx = cx;
                vy = cy;
                t  = as_e + eps_e;
            end
            default:
            begin
                direct     = 1'b1;
                direct_hit = 1'b0;
            end
        endcase
        // drop distance tests whose threshold is not positive
        if (!direct && t <= 0)
        begin
            direct     = 1'b1;
            direct_hit = 1'b0;
        end
    end

    assign prep.direct     = direct;
    assign prep.direct_hit = direct_hit;
    assign prep.dx_mag     = mag_of(vx);
    assign prep.dy_mag     = mag_of(vy);
    assign prep.thr        = t[MW-1:0];

endmodule

// File: hdl/circle_square_overlap_tester.sv
`timescale 1ns / 1ps

// channel  direction  handshake             payload
// in       input      in_valid / in_stall   operation, first_*, second_*, tolerance
// out      output     out_valid / out_stall hit
//
// One beat per cycle in and out while out is not stalled; the stages are: input register,
// geometry and threshold select, three 33x33 squarings, sum and compare.
// Reset clears the stage valid bits only; no state is kept between beats.
// A stall on out holds the pipeline; in_stall rises only when all four
// stages are full and out is stalled.

module circle_square_overlap_tester (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   operation,
    input  logic signed [csot_pkg::CW-1:0] first_x,
    input  logic signed [csot_pkg::CW-1:0] first_y,
    input  logic [csot_pkg::CW-2:0]      first_size,
    input  logic signed [csot_pkg::CW-1:0] second_x,
    input  logic signed [csot_pkg::CW-1:0] second_y,
    input  logic [csot_pkg::CW-2:0]      second_size,
    input  logic signed [csot_pkg::CW-1:0] tolerance,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit
);
    import csot_pkg::*;

    item_t          item_next, item_reg;
    prep_t          prep_next, prep_reg;
    logic [SW-1:0]  sqx_reg, sqy_reg, sqt_reg;
    logic [SW-1:0]  sqx_next, sqy_next, sqt_next;
    logic           sq_direct_reg, sq_dhit_reg;
    logic           hit_reg, hit_next;
    logic           v1_reg, v2_reg, v3_reg, v4_reg;
    logic           ready1, ready2, ready3, ready4;
    logic [SW:0]    dist_sum;

    assign item_next.operation   = operation;
    assign item_next.first_x     = first_x;
    assign item_next.first_y     = first_y;
    assign item_next.first_size  = first_size;
    assign item_next.second_x    = second_x;
    assign item_next.second_y    = second_y;
    assign item_next.second_size = second_size;
    assign item_next.tolerance   = tolerance;

    assign ready4 = !v4_reg || !out_stall;
    assign ready3 = !v3_reg || ready4;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    csot_geom u_geom (
        .item (item_reg),
        .prep (prep_next)
    );

    assign sqx_next = SW'(prep_reg.dx_mag) * SW'(prep_reg.dx_mag);
    assign sqy_next = SW'(prep_reg.dy_mag) * SW'(prep_reg.dy_mag);
    assign sqt_next = SW'(prep_reg.thr) * SW'(prep_reg.thr);

    assign dist_sum = (SW + 1)'(sqx_reg) + (SW + 1)'(sqy_reg);
    assign hit_next = sq_direct_reg ? sq_dhit_reg : (dist_sum < (SW + 1)'(sqt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= in_valid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
            if (ready4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
            item_reg <= item_next;
        if (ready2)
            prep_reg <= prep_next;
        if (ready3)
        begin
            sqx_reg       <= sqx_next;
            sqy_reg       <= sqy_next;
            sqt_reg       <= sqt_next;
            sq_direct_reg <= prep_reg.direct;
            sq_dhit_reg   <= prep_reg.direct_hit;
        end
        if (ready4)
            hit_reg <= hit_next;
    end

    assign in_stall  = !ready1;
    assign out_valid = v4_reg;
    assign hit       = hit_reg;

endmodule

// File: hdl/csot_checker.sv
`timescale 1ns / 1ps

module csot_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic hit
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit))
        else $error("stalled result beat changed");

    // drop out_valid only after a taken beat
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result beat dropped without handshake");

    // stall in only when full and blocked downstream
    a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output can advance");

    // advance an accepted beat to the output while out is not stalled
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall
        ##1 !out_stall |=> out_valid)
        else $error("accepted beat did not reach the output");

endmodule

bind circle_square_overlap_tester csot_checker u_csot_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit)
);

// File: tb/tb_circle_square_overlap_tester.sv
`timescale 1ns / 1ps

class hit_scoreboard;
    bit          expected_hits[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned hits_seen;
    int unsigned op_count[8];

    function bit closer_than_limit(longint dx, longint dy, longint lim);
        logic [127:0] mx;
        logic [127:0] my;
        logic [127:0] ml;
        mx = 128'(dx < 0 ? -dx : dx);
        my = 128'(dy < 0 ? -dy : dy);
        ml = 128'(lim);
        if (lim <= 0)
        begin
            return 1'b0;
        end
        return (mx * mx + my * my) < (ml * ml);
    endfunction

    function bit predict_hit(csot_pkg::item_t q);
        longint ax, ay, as, bx, by, bs, eps, gx, gy, qx, qy;
        bit     h;
        ax  = longint'($signed(q.first_x));
        ay  = longint'($signed(q.first_y));
        as  = longint'({33'd0, q.first_size});
        bx  = longint'($signed(q.second_x));
        by  = longint'($signed(q.second_y));
        bs  = longint'({33'd0, q.second_size});
        eps = longint'($signed(q.tolerance));
        h   = 1'b0;
        case (q.operation)
            csot_pkg::OP_POINT_CIRCLE:
            begin
                h = closer_than_limit(bx - ax, by - ay, as - eps);
            end
            csot_pkg::OP_POINT_SQUARE:
            begin
                h = (bx > ax - as + eps) && (bx < ax + as - eps) &&
                    (by > ay - as + eps) && (by < ay + as - eps);
            end
            csot_pkg::OP_CIRCLE_CIRCLE:
            begin
                h = closer_than_limit(bx - ax, by - ay, as + bs + eps);
            end
            csot_pkg::OP_SQUARE_SQUARE:
            begin
                gx = (ax > bx ? ax - bx : bx - ax) - (as + bs);
                gy = (ay > by ? ay - by : by - ay) - (as + bs);
                if (gx < 0 && gy < 0)
                begin
                    h = 1'b1;
                end
                else
                begin
                    h = closer_than_limit(gx > 0 ? gx : 0, gy > 0 ? gy : 0, eps);
                end
            end
            csot_pkg::OP_CIRCLE_SQUARE:
            begin
                qx = (ax < bx - bs) ? bx - bs : ((ax > bx + bs) ? bx + bs : ax);
                qy = (ay < by - bs) ? by - bs : ((ay > by + bs) ? by + bs : ay);
                h  = closer_than_limit(ax - qx, ay - qy, as + eps);
            end
            default:
            begin
                h = 1'b0;
            end
        endcase
        return h;
    endfunction

    function void note_query(csot_pkg::item_t q);
        op_count[q.operation]++;
        expected_hits.push_back(predict_hit(q));
    endfunction

    function void check_hit(logic h);
        bit e;
        checked++;
        if (h === 1'b1)
        begin
            hits_seen++;
        end
        if (expected_hits.size() == 0)
        begin
            $error("hit: unexpected beat, expected none, actual %0b", h);
            errors++;
        end
        else
        begin
            e = expected_hits.pop_front();
            if (h !== e)
            begin
                $error("hit: expected %0b, actual %0b", e, h);
                errors++;
            end
        end
    endfunction
endclass

module tb_circle_square_overlap_tester;

    localparam int                 ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] MAXC = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINC = 32'sh8000_0000;
    localparam int                 MAXS = 32'sh7fff_ffff;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic [2:0]                        operation;
    logic signed [csot_pkg::CW-1:0]    first_x;
    logic signed [csot_pkg::CW-1:0]    first_y;
    logic [csot_pkg::CW-2:0]           first_size;
    logic signed [csot_pkg::CW-1:0]    second_x;
    logic signed [csot_pkg::CW-1:0]    second_y;
    logic [csot_pkg::CW-2:0]           second_size;
    logic signed [csot_pkg::CW-1:0]    tolerance;
    logic                              out_valid;
    logic                              out_stall;
    logic                              hit;

    hit_scoreboard board;
    bit            gaps_enabled;
    bit            stalls_enabled;
    bit            long_hold_pending;

    circle_square_overlap_tester i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .first_x     (first_x),
        .first_y     (first_y),
        .first_size  (first_size),
        .second_x    (second_x),
        .second_y    (second_y),
        .second_size (second_size),
        .tolerance   (tolerance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic csot_pkg::item_t make_query(logic [2:0] op, int fx, int fy,
                                                   int fs, int sx, int sy,
                                                   int ss, int tol);
        csot_pkg::item_t q;
        q.operation   = op;
        q.first_x     = fx;
        q.first_y     = fy;
        q.first_size  = 31'(fs);
        q.second_x    = sx;
        q.second_y    = sy;
        q.second_size = 31'(ss);
        q.tolerance   = tol;
        return q;
    endfunction

    function automatic logic [31:0] pick_extreme();
        logic [31:0] v;
        case ($urandom_range(4))
            0:       v = MINC;
            1:       v = MAXC;
            2:       v = 32'h0000_0000;
            3:       v = 32'hffff_ffff;
            default: v = 32'h0000_0001;
        endcase
        return v;
    endfunction

    function automatic csot_pkg::item_t random_query();
        csot_pkg::item_t q;
        int unsigned     cat;
        int unsigned     sh;
        cat = $urandom_range(9);
        if (cat < 2)
        begin
            q.first_x     = $urandom;
            q.first_y     = $urandom;
            q.first_size  = 31'($urandom);
            q.second_x    = $urandom;
            q.second_y    = $urandom;
            q.second_size = 31'($urandom);
            q.tolerance   = $urandom;
        end
        else if (cat == 9)
        begin
            q.first_x     = pick_extreme();
            q.first_y     = pick_extreme();
            q.first_size  = 31'(pick_extreme());
            q.second_x    = pick_extreme();
            q.second_y    = pick_extreme();
            q.second_size = 31'(pick_extreme());
            q.tolerance   = pick_extreme();
        end
        else
        begin
            sh            = $urandom_range(28);
            q.first_x     = $urandom;
            q.first_y     = $urandom;
            q.first_size  = 31'($urandom >> (sh + 1));
            q.second_size = 31'($urandom >> (sh + 1));
            q.second_x    = q.first_x + (32'($urandom >> sh) - 32'($urandom >> sh));
            q.second_y    = q.first_y + (32'($urandom >> sh) - 32'($urandom >> sh));
            q.tolerance   = 32'($urandom >> (sh + 2 + $urandom_range(6)));
            if ($urandom_range(1) == 1)
            begin
                q.tolerance = -q.tolerance;
            end
        end
        if ($urandom_range(15) == 0)
        begin
            q.operation = 3'($urandom_range(7, int'(csot_pkg::OP_CIRCLE_SQUARE) + 1));
        end
        else
        begin
            q.operation = 3'($urandom_range(int'(csot_pkg::OP_CIRCLE_SQUARE)));
        end
        return q;
    endfunction

    // enter and leave at a falling edge
    task automatic send_query(input csot_pkg::item_t q);
        while (gaps_enabled && $urandom_range(99) < 7)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        operation   = q.operation;
        first_x     = q.first_x;
        first_y     = q.first_y;
        first_size  = q.first_size;
        second_x    = q.second_x;
        second_y    = q.second_y;
        second_size = q.second_size;
        tolerance   = q.tolerance;
        in_valid    = 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        board.note_query(q);
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && long_hold_pending)
            begin
                hold_left         = 80;
                long_hold_pending = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall = stalls_enabled && ($urandom_range(99) < 7);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            board.check_hit(hit);
        end
    end

    initial
    begin
        csot_pkg::item_t directed[$];
        int              k;
        board             = new();
        gaps_enabled      = 1'b1;
        stalls_enabled    = 1'b1;
        long_hold_pending = 1'b0;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        operation         = '0;
        first_x           = '0;
        first_y           = '0;
        first_size        = '0;
        second_x          = '0;
        second_y          = '0;
        second_size       = '0;
        tolerance         = '0;

        directed.push_back(make_query(csot_pkg::OP_POINT_CIRCLE, 0, 0, ONE, 0, 0, MAXS, 0));
        directed.push_back(make_query(csot_pkg::OP_POINT_CIRCLE, 0, 0, ONE, ONE, 0, 0, 0));
        directed.push_back(make_query(csot_pkg::OP_POINT_CIRCLE, 0, 0, ONE, 0, 0, 0, ONE));
        directed.push_back(make_query(csot_pkg::OP_POINT_CIRCLE, 0, 0, ONE, 0, 0, 0, 2 * ONE));
        directed.push_back(make_query(csot_pkg::OP_POINT_CIRCLE, MINC, MINC, 0,
                                      MAXC, MAXC, 0, MINC));
        directed.push_back(make_query(csot_pkg::OP_POINT_SQUARE, 0, 0, ONE,
                                      ONE / 2, -ONE / 2, MAXS, 0));
        directed.push_back(make_query(csot_pkg::OP_POINT_SQUARE, 0, 0, ONE, ONE, 0, 0, 0));
        directed.push_back(make_query(csot_pkg::OP_POINT_SQUARE, 0, 0, ONE,
                                      ONE / 2, 0, 0, ONE / 2));
        directed.push_back(make_query(csot_pkg::OP_POINT_SQUARE, MAXC, MAXC, MAXS,
                                      MINC, MINC, 0, MINC));
        directed.push_back(make_query(csot_pkg::OP_CIRCLE_CIRCLE, 0, 0, ONE,
                                      2 * ONE, 0, ONE, 0));
        directed.push_back(make_query(csot_pkg::OP_CIRCLE_CIRCLE, 0, 0, ONE,
                                      2 * ONE - 1, 0, ONE, 0));
        directed.push_back(make_query(csot_pkg::OP_CIRCLE_CIRCLE, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_query(csot_pkg::OP_CIRCLE_CIRCLE, MINC, MINC, MAXS,
                                      MAXC, MAXC, MAXS, MAXC));
        directed.push_back(make_query(csot_pkg::OP_SQUARE_SQUARE, 0, 0, ONE,
                                      ONE, ONE, ONE, 0));
        directed.push_back(make_query(csot_pkg::OP_SQUARE_SQUARE, 0, 0, ONE,
                                      2 * ONE, 0, ONE, 0));
        directed.push_back(make_query(csot_pkg::OP_SQUARE_SQUARE, 0, 0, ONE,
                                      3 * ONE, 3 * ONE, ONE, 2 * ONE));
        directed.push_back(make_query(csot_pkg::OP_SQUARE_SQUARE, MINC, MINC, 0,
                                      MAXC, MAXC, 0, MAXC));
        directed.push_back(make_query(csot_pkg::OP_CIRCLE_SQUARE, 0, 0, ONE,
                                      2 * ONE, 0, ONE, 0));
        directed.push_back(make_query(csot_pkg::OP_CIRCLE_SQUARE, 0, 0, ONE,
                                      2 * ONE, 2 * ONE, ONE, 0));
        directed.push_back(make_query(csot_pkg::OP_CIRCLE_SQUARE, 0, 0, ONE,
                                      2 * ONE, 2 * ONE, ONE, ONE));
        directed.push_back(make_query(csot_pkg::OP_CIRCLE_SQUARE, 0, 0, 0, 0, 0, MAXS, 0));
        directed.push_back(make_query(csot_pkg::OP_CIRCLE_SQUARE, MAXC, MINC, MAXS,
                                      MINC, MAXC, MAXS, MAXC));
        for (k = int'(csot_pkg::OP_CIRCLE_SQUARE) + 1; k < 8; k++)
        begin
            directed.push_back(make_query(3'(k), 0, 0, ONE, 0, 0, ONE, 0));
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            send_query(directed[i]);
        end

        for (k = 0; k < 1200; k++)
        begin
            gaps_enabled   = !(k >= 500 && k < 750);
            stalls_enabled = gaps_enabled;
            if (k == 300 || k == 900)
            begin
                long_hold_pending = 1'b1;
            end
            send_query(random_query());
        end
        in_valid = 1'b0;

        while (board.expected_hits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);

        $display("Checked %0d results (%0d hits): point-circle %0d, point-square %0d,",
                 board.checked, board.hits_seen,
                 board.op_count[csot_pkg::OP_POINT_CIRCLE],
                 board.op_count[csot_pkg::OP_POINT_SQUARE]);
        $display("circle-circle %0d, square-square %0d, circle-square %0d, undefined ops %0d",
                 board.op_count[csot_pkg::OP_CIRCLE_CIRCLE],
                 board.op_count[csot_pkg::OP_SQUARE_SQUARE],
                 board.op_count[csot_pkg::OP_CIRCLE_SQUARE],
                 board.op_count[5] + board.op_count[6] + board.op_count[7]);
        if (board.errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
